FILE: sv/mapu_pkg.sv
// Shared constants, codes and handshake structs for the modular power unit.
package mapu_pkg;

   localparam int OPERAND_BITS = 31;
   localparam int CNT_BITS     = $clog2(OPERAND_BITS);

   localparam logic [OPERAND_BITS-1:0] MODULUS_RESET = OPERAND_BITS'(64'd1000000007);
   localparam logic [OPERAND_BITS-1:0] OP_ONE        = OPERAND_BITS'(1);
   localparam logic [OPERAND_BITS-1:0] OP_TWO        = OPERAND_BITS'(2);

   localparam logic [1:0] ACT_MUL   = 2'd0;
   localparam logic [1:0] ACT_POW   = 2'd1;
   localparam logic [1:0] ACT_TOWER = 2'd2;

   typedef struct packed {
      logic                    start;
      logic [OPERAND_BITS-1:0] mult;
      logic [OPERAND_BITS-1:0] scan;
      logic [OPERAND_BITS-1:0] md;
   } mapu_mm_cmd_type;

   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic [OPERAND_BITS-1:0] value;
   } mapu_mm_rsp_type;

endpackage

FILE: sv/mapu_if.sv
// Valid/ready channel interfaces for requests and responses.
interface mapu_req_if;
   import mapu_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [1:0]              action;
   logic [OPERAND_BITS-1:0] base;
   logic [OPERAND_BITS-1:0] operand_b;
   logic [OPERAND_BITS-1:0] operand_c;

   modport source (output valid, output action, output base, output operand_b,
                   output operand_c, input ready);
   modport sink   (input valid, input action, input base, input operand_b,
                   input operand_c, output ready);
endinterface

interface mapu_rsp_if;
   import mapu_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OPERAND_BITS-1:0] result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

FILE: sv/modular_arith_power_unit.sv
// Top level: modular multiply, power and tower power over a configured modulus.
//
// Requests arrive on req_if (valid/ready) with an action code and three operands:
//   multiply: base*operand_b mod m, power: base^operand_b mod m,
//   tower: base^(operand_b^operand_c) mod m, inner exponent reduced mod m-1.
// Each transaction yields exactly one response on rsp_if (valid/ready).
// The modulus m is written through csr_we/csr_wdata; the user must write it
// only while the unit is idle, as the block itself does not enforce this.
// Reset sets m to 1000000007 and returns the sequencer to idle. One request
// is in flight at a time: req_if.ready is high only when idle. Every modular
// product runs on one shared bit-serial multiplier over the 31 operand bits.
// Multiply reduces the base, then forms the product; power reduces the base,
// then scans the exponent LSB first, multiplying for each set bit and squaring
// for each bit; tower is two such passes (one when operand_c is zero).
// A modulus below two or an unused action code answers with zero in the cycle
// after acceptance; the next request is taken in the cycle after the response.
// The result is held in a register until rsp_if.ready; a stalled receiver
// simply holds the unit in its output state, nothing is lost.
module modular_arith_power_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mapu_pkg::OPERAND_BITS-1:0]   csr_wdata,
   mapu_req_if.sink                            req_if,
   mapu_rsp_if.source                          rsp_if
);
   import mapu_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RED   = 3'd1;
   localparam logic [2:0] S_PROD  = 3'd2;
   localparam logic [2:0] S_PSTEP = 3'd3;
   localparam logic [2:0] S_PMUL  = 3'd4;
   localparam logic [2:0] S_PSQR  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [OPERAND_BITS-1:0] modulus_ff;
   logic                    inner_ff, inner_in;
   logic [1:0]              action_ff, action_in;
   logic [OPERAND_BITS-1:0] base_ff, base_in;
   logic [OPERAND_BITS-1:0] opb_ff, opb_in;
   logic [OPERAND_BITS-1:0] md_ff, md_in;
   logic [OPERAND_BITS-1:0] x_ff, x_in;
   logic [OPERAND_BITS-1:0] r_ff, r_in;
   logic [OPERAND_BITS-1:0] exp_ff, exp_in;

   mapu_mm_cmd_type mm_cmd;
   mapu_mm_rsp_type mm_rsp;

   mapu_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .cmd   (mm_cmd),
      .rsp   (mm_rsp)
   );

   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_if.valid  = (state_ff == S_OUT);
   assign rsp_if.result = r_ff;

   always_comb begin
      state_in  = state_ff;
      inner_in  = inner_ff;
      action_in = action_ff;
      base_in   = base_ff;
      opb_in    = opb_ff;
      md_in     = md_ff;
      x_in      = x_ff;
      r_in      = r_ff;
      exp_in    = exp_ff;
      mm_cmd.start = 1'b0;
      mm_cmd.mult  = x_ff;
      mm_cmd.scan  = x_ff;
      mm_cmd.md    = md_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               action_in = req_if.action;
               base_in   = req_if.base;
               opb_in    = req_if.operand_b;
               if (modulus_ff < OP_TWO) begin
                  r_in     = '0;
                  state_in = S_OUT;
               end else begin
                  case (req_if.action)
                     ACT_MUL, ACT_POW: begin
                        inner_in     = 1'b0;
                        md_in        = modulus_ff;
                        exp_in       = req_if.operand_b;
                        mm_cmd.start = 1'b1;
                        mm_cmd.mult  = OP_ONE;
                        mm_cmd.scan  = req_if.base;
                        mm_cmd.md    = modulus_ff;
                        state_in     = S_RED;
                     end
                     ACT_TOWER: begin
                        mm_cmd.start = 1'b1;
                        mm_cmd.mult  = OP_ONE;
                        state_in     = S_RED;
                        if (req_if.operand_c == '0) begin
                           // exponent is one, left unreduced
                           inner_in    = 1'b0;
                           md_in       = modulus_ff;
                           exp_in      = OP_ONE;
                           mm_cmd.scan = req_if.base;
                           mm_cmd.md   = modulus_ff;
                        end else begin
                           inner_in    = 1'b1;
                           md_in       = modulus_ff - OP_ONE;
                           exp_in      = req_if.operand_c;
                           mm_cmd.scan = req_if.operand_b;
                           mm_cmd.md   = modulus_ff - OP_ONE;
                        end
                     end
                     default: begin
                        r_in     = '0;
                        state_in = S_OUT;
                     end
                  endcase
               end
            end
         end
         S_RED: begin
            if (mm_rsp.done) begin
               x_in = mm_rsp.value;
               if (action_ff == ACT_MUL) begin
                  mm_cmd.start = 1'b1;
                  mm_cmd.mult  = mm_rsp.value;
                  mm_cmd.scan  = opb_ff;
                  state_in     = S_PROD;
               end else begin
                  r_in     = OP_ONE;
                  state_in = S_PSTEP;
               end
            end
         end
         S_PROD: begin
            if (mm_rsp.done) begin
               r_in     = mm_rsp.value;
               state_in = S_OUT;
            end
         end
         S_PSTEP: begin
            if (exp_ff == '0) begin
               if (inner_ff) begin
                  // inner exponent done: now raise the base mod m
                  inner_in     = 1'b0;
                  exp_in       = r_ff;
                  md_in        = modulus_ff;
                  mm_cmd.start = 1'b1;
                  mm_cmd.mult  = OP_ONE;
                  mm_cmd.scan  = base_ff;
                  mm_cmd.md    = modulus_ff;
                  state_in     = S_RED;
               end else begin
                  state_in = S_OUT;
               end
            end else if (exp_ff[0]) begin
               mm_cmd.start = 1'b1;
               mm_cmd.scan  = r_ff;
               state_in     = S_PMUL;
            end else begin
               mm_cmd.start = 1'b1;
               state_in     = S_PSQR;
            end
         end
         S_PMUL: begin
            if (mm_rsp.done) begin
               r_in         = mm_rsp.value;
               mm_cmd.start = 1'b1;
               state_in     = S_PSQR;
            end
         end
         S_PSQR: begin
            if (mm_rsp.done) begin
               x_in     = mm_rsp.value;
               exp_in   = {1'b0, exp_ff[OPERAND_BITS-1:1]};
               state_in = S_PSTEP;
            end
         end
         S_OUT: begin
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         modulus_ff <= MODULUS_RESET;
         inner_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         inner_ff <= inner_in;
         if (csr_we) begin
            modulus_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      base_ff   <= base_in;
      opb_ff    <= opb_in;
      md_ff     <= md_in;
      x_ff      <= x_in;
      r_ff      <= r_in;
      exp_ff    <= exp_in;
   end

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ((modulus_ff < OP_TWO) ? (r_ff == '0) : (r_ff < modulus_ff)))
      else $error("response not reduced modulo m");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      mm_rsp.done |-> (state_ff == S_RED || state_ff == S_PROD ||
                       state_ff == S_PMUL || state_ff == S_PSQR))
      else $error("multiplier finished with no product awaited");

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (mm_cmd.start && state_ff == S_IDLE) |=> (state_ff == S_RED))
      else $error("sequencer did not follow the operand reduction");

   a_inner_mod: assert property (@(posedge clock) disable iff (reset)
      (inner_ff && state_ff != S_IDLE) |-> (md_ff == modulus_ff - OP_ONE))
      else $error("tower exponent not reduced modulo m-1");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mm_rsp.busy)
      else $error("multiplier busy while sequencer idle");

endmodule

FILE: sv/mapu_mulmod.sv
// Bit-serial interleaved modular multiplier, MSB first, one operand bit per cycle.
module mapu_mulmod (
   input  logic                      clock,
   input  logic                      reset,
   input  mapu_pkg::mapu_mm_cmd_type cmd,
   output mapu_pkg::mapu_mm_rsp_type rsp
);
   import mapu_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [OPERAND_BITS-1:0]   acc_ff, acc_in;
   logic [OPERAND_BITS-1:0]   scan_ff, scan_in;
   logic [OPERAND_BITS-1:0]   mult_ff, mult_in;
   logic [OPERAND_BITS-1:0]   md_ff, md_in;
   logic [OPERAND_BITS+1:0]   sum;
   logic [OPERAND_BITS+1:0]   md1;
   logic [OPERAND_BITS+1:0]   md2;
   logic [OPERAND_BITS+1:0]   red;

   // acc < md and mult < md (or mult == 1), so sum < 3*md: at most two subtractions
   always_comb begin
      sum = {1'b0, acc_ff, 1'b0}
          + {2'b00, (scan_ff[OPERAND_BITS-1] ? mult_ff : '0)};
      md1 = {2'b00, md_ff};
      md2 = {1'b0, md_ff, 1'b0};
      if (sum >= md2) begin
         red = sum - md2;
      end else if (sum >= md1) begin
         red = sum - md1;
      end else begin
         red = sum;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      scan_in = scan_ff;
      mult_in = mult_ff;
      md_in   = md_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(OPERAND_BITS - 1);
         acc_in  = '0;
         scan_in = cmd.scan;
         mult_in = cmd.mult;
         md_in   = cmd.md;
      end else if (busy_ff) begin
         acc_in  = red[OPERAND_BITS-1:0];
         scan_in = {scan_ff[OPERAND_BITS-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      scan_ff <= scan_in;
      mult_ff <= mult_in;
      md_ff   <= md_in;
   end

   assign rsp.busy  = busy_ff;
   assign rsp.done  = done_ff;
   assign rsp.value = acc_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("multiplier restarted while busy");

   a_done_bounded: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (acc_ff < md_ff))
      else $error("multiplier result not reduced");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("multiplier done held for more than one cycle");

endmodule
